[hdl/mp2d_pkg.sv]
// Shared types, constants and a helper function of the max pooling unit.
package mp2d_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int MAX_KERNEL  = 8;
   localparam int KER_W       = 4;
   localparam int POS_W       = 9;
   localparam int COUNT_W     = 17;
   localparam int INDEX_W     = 16;
   localparam int ORD_W       = 8;
   localparam int PLANE_W     = 16;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_INDEX_W = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KERNEL       = 3'd0,
      CSR_STRIDE       = 3'd1,
      CSR_PLANE_HEIGHT = 3'd2,
      CSR_PLANE_WIDTH  = 3'd3,
      CSR_PLANE_COUNT  = 3'd4
   } csr_index_type;

   // Position of a row or column relative to the stride grid of window origins.
   typedef struct packed {
      logic [KER_W-1:0] phase;
      logic [ORD_W-1:0] ord;
   } phase_type;

   // Phase of a new position; origins start once the position reaches kernel - 1.
   function automatic phase_type phase_next(input logic [POS_W-1:0] pos_new,
                                            input logic [KER_W-1:0] km1,
                                            input logic [KER_W-1:0] stride,
                                            input phase_type        cur);
      phase_type nx;
      nx = cur;
      if (pos_new <= POS_W'(km1)) begin
         nx.phase = '0;
         nx.ord   = '0;
      end else if (cur.phase == stride - KER_W'(1)) begin
         nx.phase = '0;
         nx.ord   = cur.ord + ORD_W'(1);
      end else begin
         nx.phase = cur.phase + KER_W'(1);
      end
      return nx;
   endfunction

endpackage

[hdl/max_pool_2d_with_argmax_unit.sv]
// Streaming 2-D max pooling with argmax over raster-order feature-map planes.
// A pixel that completes no window is taken without a stall; the next can follow at once.
// A pixel that completes a window stalls the request side while its window is scanned: one line
// store read per window sample through the single read port, one drain, one emit; its
// result then goes to the result register, later while a previous result is still held.
// Synchronous active-high reset restores default registers, the stream origin, the scan state and rsp_valid.
module max_pool_2d_with_argmax_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [mp2d_pkg::SAMPLE_BITS-1:0] req_pixel_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [mp2d_pkg::SAMPLE_BITS-1:0] rsp_max_value,
   output logic [mp2d_pkg::INDEX_W-1:0]           rsp_argmax_index,
   output logic [mp2d_pkg::ORD_W-1:0]             rsp_out_row,
   output logic [mp2d_pkg::ORD_W-1:0]             rsp_out_col,
   output logic [mp2d_pkg::PLANE_W-1:0]           rsp_plane_number,
   output logic                                   rsp_last_of_plane,
   input  logic                                   csr_wr_en,
   input  logic [mp2d_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mp2d_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int MAX_WIDTH  = mp2d_pkg::MAX_WIDTH;
   localparam int MAX_HEIGHT = mp2d_pkg::MAX_HEIGHT;
   localparam int MAX_KERNEL = mp2d_pkg::MAX_KERNEL;
   localparam int KER_W   = mp2d_pkg::KER_W;
   localparam int POS_W   = mp2d_pkg::POS_W;
   localparam int IDX_W   = mp2d_pkg::INDEX_W;
   localparam int SMP_W   = mp2d_pkg::SAMPLE_BITS;
   localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int SLOT_W  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int ADDR_W  = SLOT_W + COL_W;
   localparam int RAM_DEPTH = 2 ** ADDR_W;

   // Configuration registers.
   logic [KER_W-1:0]                 kernel_ff, kernel_in;
   logic [KER_W-1:0]                 stride_ff, stride_in;
   logic [POS_W-1:0]                 height_ff, height_in;
   logic [POS_W-1:0]                 width_ff, width_in;
   logic [mp2d_pkg::COUNT_W-1:0]     count_ff, count_in;

   // Stream position.
   logic [POS_W-1:0]                 row_ff, row_in;
   logic [POS_W-1:0]                 col_ff, col_in;
   logic [KER_W-1:0]                 slot_ff, slot_in;
   mp2d_pkg::phase_type              row_phase_ff, row_phase_in;
   mp2d_pkg::phase_type              col_phase_ff, col_phase_in;
   logic [mp2d_pkg::PLANE_W-1:0]     plane_ff, plane_in;
   logic [IDX_W-1:0]                 pix_ff, pix_in;

   // Window scan sequencer.
   mp2d_pkg::state_type              state_ff, state_in;
   logic [KER_W-1:0]                 rd_slot_ff, rd_slot_in;
   logic [POS_W-1:0]                 rd_col_ff, rd_col_in;
   logic [POS_W-1:0]                 col0_ff, col0_in;
   logic [KER_W-1:0]                 i_ff, i_in;
   logic [KER_W-1:0]                 j_ff, j_in;
   logic [IDX_W-1:0]                 idx_ff, idx_in;
   logic                             rd_pend_ff, rd_pend_in;
   logic                             rd_first_ff, rd_first_in;
   logic [IDX_W-1:0]                 rd_idx_ff, rd_idx_in;
   logic signed [SMP_W-1:0]          best_ff, best_in;
   logic [IDX_W-1:0]                 best_idx_ff, best_idx_in;
   logic [mp2d_pkg::ORD_W-1:0]       win_row_ff, win_row_in;
   logic [mp2d_pkg::ORD_W-1:0]       win_col_ff, win_col_in;
   logic [mp2d_pkg::PLANE_W-1:0]     win_plane_ff, win_plane_in;
   logic                             win_last_ff, win_last_in;

   // Result register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [SMP_W-1:0]          rsp_max_ff, rsp_max_in;
   logic [IDX_W-1:0]                 rsp_idx_ff, rsp_idx_in;
   logic [mp2d_pkg::ORD_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [mp2d_pkg::ORD_W-1:0]       rsp_col_ff, rsp_col_in;
   logic [mp2d_pkg::PLANE_W-1:0]     rsp_plane_ff, rsp_plane_in;
   logic                             rsp_last_ff, rsp_last_in;

   // Effective configuration and helpers.
   logic [KER_W-1:0]                 k_eff, km1, s_eff;
   logic [POS_W-1:0]                 h_eff, w_eff;
   logic [mp2d_pkg::COUNT_W-1:0]     n_eff;
   logic                             accept, win_hit, win_last, col_wrap, row_wrap;
   logic                             last_elem;
   logic [13:0]                      tl_off;
   logic [IDX_W-1:0]                 row_step;
   logic                             ram_rd_en;
   logic [ADDR_W-1:0]                ram_wr_addr, ram_rd_addr;
   logic signed [SMP_W-1:0]          ram_rd_data;

   assign k_eff = (kernel_ff == '0) ? KER_W'(1) :
                  (32'(kernel_ff) > MAX_KERNEL) ? KER_W'(MAX_KERNEL) : kernel_ff;
   assign km1   = k_eff - KER_W'(1);
   assign s_eff = (stride_ff == '0) ? KER_W'(1) : stride_ff;
   assign h_eff = (height_ff == '0) ? POS_W'(1) :
                  (32'(height_ff) > MAX_HEIGHT) ? POS_W'(MAX_HEIGHT) : height_ff;
   assign w_eff = (width_ff == '0) ? POS_W'(1) :
                  (32'(width_ff) > MAX_WIDTH) ? POS_W'(MAX_WIDTH) : width_ff;
   assign n_eff = (count_ff == '0) ? 17'd1 :
                  (count_ff > 17'd65536) ? 17'd65536 : count_ff;

   assign accept   = (state_ff == mp2d_pkg::ST_IDLE) && req_valid;
   assign win_hit  = (POS_W'(k_eff) <= h_eff) && (POS_W'(k_eff) <= w_eff)
                     && (row_ff >= POS_W'(km1)) && (col_ff >= POS_W'(km1))
                     && (row_phase_ff.phase == '0) && (col_phase_ff.phase == '0);
   // On the stride grid, an origin is the last one when one more stride would overrun.
   assign win_last = ((10'(row_ff) + 10'(s_eff)) >= 10'(h_eff))
                     && ((10'(col_ff) + 10'(s_eff)) >= 10'(w_eff));
   assign col_wrap = (col_ff == w_eff - POS_W'(1));
   assign row_wrap = (row_ff == h_eff - POS_W'(1));
   assign last_elem = (i_ff == km1) && (j_ff == km1);
   assign tl_off   = 14'(km1) * (14'(w_eff) + 14'd1);
   assign row_step = IDX_W'(w_eff) + IDX_W'(1) - IDX_W'(k_eff);

   assign ram_rd_en   = (state_ff == mp2d_pkg::ST_SCAN);
   assign ram_wr_addr = {SLOT_W'(slot_ff), COL_W'(col_ff)};
   assign ram_rd_addr = {SLOT_W'(rd_slot_ff), COL_W'(rd_col_ff)};

   mp2d_ram #(
      .WIDTH (SMP_W),
      .DEPTH (RAM_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (ram_wr_addr),
      .wr_data (req_pixel_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      kernel_in     = kernel_ff;
      stride_in     = stride_ff;
      height_in     = height_ff;
      width_in      = width_ff;
      count_in      = count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      slot_in       = slot_ff;
      row_phase_in  = row_phase_ff;
      col_phase_in  = col_phase_ff;
      plane_in      = plane_ff;
      pix_in        = pix_ff;
      state_in      = state_ff;
      rd_slot_in    = rd_slot_ff;
      rd_col_in     = rd_col_ff;
      col0_in       = col0_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      idx_in        = idx_ff;
      rd_pend_in    = 1'b0;
      rd_first_in   = rd_first_ff;
      rd_idx_in     = rd_idx_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      win_row_in    = win_row_ff;
      win_col_in    = win_col_ff;
      win_plane_in  = win_plane_ff;
      win_last_in   = win_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_max_in    = rsp_max_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_plane_in  = rsp_plane_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         mp2d_pkg::ST_IDLE: begin
            if (accept) begin
               // Advance the raster position past this pixel.
               if (col_wrap) begin
                  col_in = '0;
                  if (row_wrap) begin
                     row_in  = '0;
                     slot_in = '0;
                     pix_in  = '0;
                     if ((17'(plane_ff) + 17'd1) >= n_eff) begin
                        plane_in = '0;
                     end else begin
                        plane_in = plane_ff + mp2d_pkg::PLANE_W'(1);
                     end
                  end else begin
                     row_in  = row_ff + POS_W'(1);
                     slot_in = (slot_ff == km1) ? '0 : slot_ff + KER_W'(1);
                     pix_in  = pix_ff + IDX_W'(1);
                  end
                  row_phase_in = mp2d_pkg::phase_next(row_in, km1, s_eff, row_phase_ff);
               end else begin
                  col_in = col_ff + POS_W'(1);
                  pix_in = pix_ff + IDX_W'(1);
               end
               col_phase_in = mp2d_pkg::phase_next(col_in, km1, s_eff, col_phase_ff);

               if (win_hit) begin
                  // The window's top row sits one slot after the current row, modulo kernel.
                  rd_slot_in   = (slot_ff == km1) ? '0 : slot_ff + KER_W'(1);
                  rd_col_in    = col_ff - POS_W'(km1);
                  col0_in      = col_ff - POS_W'(km1);
                  i_in         = '0;
                  j_in         = '0;
                  idx_in       = pix_ff - IDX_W'(tl_off);
                  win_row_in   = row_phase_ff.ord;
                  win_col_in   = col_phase_ff.ord;
                  win_plane_in = plane_ff;
                  win_last_in  = win_last;
                  state_in     = mp2d_pkg::ST_SCAN;
               end
            end
         end
         mp2d_pkg::ST_SCAN: begin
            rd_pend_in  = 1'b1;
            rd_first_in = (i_ff == '0) && (j_ff == '0);
            rd_idx_in   = idx_ff;
            if (j_ff == km1) begin
               j_in       = '0;
               i_in       = i_ff + KER_W'(1);
               rd_col_in  = col0_ff;
               rd_slot_in = (rd_slot_ff == km1) ? '0 : rd_slot_ff + KER_W'(1);
               idx_in     = idx_ff + row_step;
            end else begin
               j_in      = j_ff + KER_W'(1);
               rd_col_in = rd_col_ff + POS_W'(1);
               idx_in    = idx_ff + IDX_W'(1);
            end
            if (last_elem) begin
               state_in = mp2d_pkg::ST_DRAIN;
            end
         end
         mp2d_pkg::ST_DRAIN: begin
            state_in = mp2d_pkg::ST_EMIT;
         end
         mp2d_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = best_ff;
               rsp_idx_in   = best_idx_ff;
               rsp_row_in   = win_row_ff;
               rsp_col_in   = win_col_ff;
               rsp_plane_in = win_plane_ff;
               rsp_last_in  = win_last_ff;
               state_in     = mp2d_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mp2d_pkg::ST_IDLE;
         end
      endcase

      // Shared compare unit: strict greater-than keeps the first maximum in row order.
      if (rd_pend_ff && (rd_first_ff || (ram_rd_data > best_ff))) begin
         best_in     = ram_rd_data;
         best_idx_in = rd_idx_ff;
      end

      if (csr_wr_en) begin
         case (mp2d_pkg::csr_index_type'(csr_index))
            mp2d_pkg::CSR_KERNEL:       kernel_in = csr_wdata[KER_W-1:0];
            mp2d_pkg::CSR_STRIDE:       stride_in = csr_wdata[KER_W-1:0];
            mp2d_pkg::CSR_PLANE_HEIGHT: height_in = csr_wdata[POS_W-1:0];
            mp2d_pkg::CSR_PLANE_WIDTH:  width_in  = csr_wdata[POS_W-1:0];
            mp2d_pkg::CSR_PLANE_COUNT:  count_in  = csr_wdata;
            default: ;
         endcase
         // Any register write restarts the stream at the origin of plane zero.
         if ((csr_index == mp2d_pkg::CSR_KERNEL) || (csr_index == mp2d_pkg::CSR_STRIDE)
             || (csr_index == mp2d_pkg::CSR_PLANE_HEIGHT)
             || (csr_index == mp2d_pkg::CSR_PLANE_WIDTH)
             || (csr_index == mp2d_pkg::CSR_PLANE_COUNT)) begin
            row_in       = '0;
            col_in       = '0;
            slot_in      = '0;
            row_phase_in = '0;
            col_phase_in = '0;
            plane_in     = '0;
            pix_in       = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff    <= KER_W'(2);
         stride_ff    <= KER_W'(2);
         height_ff    <= POS_W'(256);
         width_ff     <= POS_W'(256);
         count_ff     <= mp2d_pkg::COUNT_W'(1);
         row_ff       <= '0;
         col_ff       <= '0;
         slot_ff      <= '0;
         row_phase_ff <= '0;
         col_phase_ff <= '0;
         plane_ff     <= '0;
         pix_ff       <= '0;
         state_ff     <= mp2d_pkg::ST_IDLE;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kernel_ff    <= kernel_in;
         stride_ff    <= stride_in;
         height_ff    <= height_in;
         width_ff     <= width_in;
         count_ff     <= count_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         slot_ff      <= slot_in;
         row_phase_ff <= row_phase_in;
         col_phase_ff <= col_phase_in;
         plane_ff     <= plane_in;
         pix_ff       <= pix_in;
         state_ff     <= state_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff   <= rd_slot_in;
      rd_col_ff    <= rd_col_in;
      col0_ff      <= col0_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      idx_ff       <= idx_in;
      rd_first_ff  <= rd_first_in;
      rd_idx_ff    <= rd_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      win_row_ff   <= win_row_in;
      win_col_ff   <= win_col_in;
      win_plane_ff <= win_plane_in;
      win_last_ff  <= win_last_in;
      rsp_max_ff   <= rsp_max_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_plane_ff <= rsp_plane_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall         = (state_ff != mp2d_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_max_value     = rsp_max_ff;
   assign rsp_argmax_index  = rsp_idx_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_plane_number  = rsp_plane_ff;
   assign rsp_last_of_plane = rsp_last_ff;

   // A window pixel always starts a scan on the next cycle.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (accept && win_hit) |=> (state_ff == mp2d_pkg::ST_SCAN))
      else $error("window pixel did not start a scan");

   // Every scan cycle issues a read whose data reaches the compare unit next cycle.
   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mp2d_pkg::ST_SCAN) |=> rd_pend_ff)
      else $error("scan read not followed by compare");

   // A finished window waits while the result register is still held.
   a_emit_waits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == mp2d_pkg::ST_EMIT) && rsp_valid_ff && rsp_stall)
      |=> (state_ff == mp2d_pkg::ST_EMIT))
      else $error("result register overwritten while stalled");

endmodule

[hdl/mp2d_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mp2d_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
